// ===== design/dftrb_pkg.sv =====
// Shared types, codes and constants for the DFT real-bin engine.
// Holds the request/response beat structs and the Q2.14 cosine table.
// No dependencies.
package dftrb_pkg;

   localparam int POINTS       = 128;
   localparam int ADDR_W       = $clog2(POINTS);
   localparam int INDEX_W      = 7;
   localparam int SAMPLE_W     = 16;
   localparam int COS_W        = 16;
   localparam int RESULT_W     = 16;
   localparam int Q_SHIFT      = 14;
   localparam int SERIES_TERMS = 12;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // Denominators (2n-1)*(2n) of the cosine series.
   localparam longint unsigned SERIES_DIV [SERIES_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_BIN   = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [INDEX_W-1:0]  index;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] bin_real;
      logic [INDEX_W-1:0]         bin_number;
      logic                       saturated;
   } rsp_type;

   typedef logic [POINTS-1:0][COS_W-1:0] cos_table_type;

   // Elaboration-time build of cos(2*pi*p/POINTS) in Q2.14.
   function automatic cos_table_type build_cos_table();
      cos_table_type     tab;
      longint unsigned   p;
      longint unsigned   a;
      longint unsigned   theta;
      longint unsigned   t2;
      longint unsigned   term;
      longint            sum;
      logic [COS_W-1:0]  qv;
      logic              neg;
      for (int i = 0; i < POINTS; i++) begin
         p   = longint'(i);
         neg = 1'b0;
         if (2 * p > POINTS) p = POINTS - p;
         a = 2 * p;
         if (2 * a > POINTS) begin
            a   = POINTS - a;
            neg = 1'b1;
         end
         theta = (PI_Q30 * a) / POINTS;
         t2    = (theta * theta) >> 30;
         term  = 64'd1 << 30;
         sum   = longint'(term);
         for (int n = 0; n < SERIES_TERMS; n++) begin
            term = ((term * t2) >> 30) / SERIES_DIV[n];
            if (n % 2 == 0) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         qv = COS_W'((longint'(sum) + 32768) >>> 16);
         tab[i] = neg ? -qv : qv;
      end
      return tab;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

// ===== design/dft_real_bin_engine.sv =====
// Top level of the DFT real-bin engine: sample store, MAC loop, rounding.
// Depends on dftrb_pkg and dftrb_ram.
//
//   channel | ports                 | handshake
//   --------+-----------------------+-------------------------------------
//   request | start, busy, req_data | beat taken when start && !busy
//   result  | rsp_valid, rsp_data   | one-cycle strobe, cannot be held off
//
// Sequence: a sample write is taken and busy stays low. A bin request steps
//   through RUN, DRAIN, ABS and ROUND; the one read port of the sample RAM
//   feeds one multiply-accumulate per cycle in RUN. The result strobe rises
//   as busy drops, so the next beat can be taken while the result is shown.
// Reset: after reset a clearing pass writes zero to all 128 sample entries,
//   one a cycle; busy is high throughout the pass.
// Stalls: the receiver cannot stall; a result is shown for one cycle only.
module dft_real_bin_engine
   import dftrb_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // x (unsigned, zero-extended) times signed Q2.14 cosine
   localparam int PROD_W = SAMPLE_BITS + 1 + COS_W;
   // room for POINTS products plus sign
   localparam int ACC_W  = PROD_W + ADDR_W;
   localparam int RND_W  = ACC_W + 1 - Q_SHIFT;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ABS,
      ST_ROUND
   } state_type;

   state_type state_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // datapath
   logic [ADDR_W-1:0]         k_ff;
   logic [ADDR_W-1:0]         phase_ff;
   logic [INDEX_W-1:0]        bin_ff;
   logic                      rd_v_ff;
   logic                      prod_v_ff;
   logic signed [COS_W-1:0]   cos_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]          mag_ff;
   logic [ACC_W-1:0]          mag_in;
   logic                      neg_ff;
   logic [ACC_W:0]            round_sum;
   logic [RND_W-1:0]          rnd;
   rsp_type                   rsp_in;

   // RAM ports
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   logic accept;
   logic accept_bin;
   logic accept_wr;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign accept_bin = accept && (req_data.cmd == CMD_BIN);
   assign accept_wr  = accept && (req_data.cmd == CMD_WRITE);

   // Write port: clearing pass after reset, otherwise sample write beats.
   // Index is as wide as the address, so every write lands in range.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = accept_wr;
         ram_waddr = ADDR_W'(req_data.index);
         ram_wdata = req_data.sample[SAMPLE_BITS-1:0];
      end
   end

   dftrb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (POINTS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // Rounding: half away from zero on magnitude, then clamp to int16.
   always_comb begin
      mag_in    = acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
      round_sum = {1'b0, mag_ff} + (ACC_W+1)'(1 << (Q_SHIFT - 1));
      rnd       = round_sum[ACC_W:Q_SHIFT];
      rsp_in.bin_number = bin_ff;
      if (neg_ff) begin
         if (rnd > RND_W'(32768)) begin
            rsp_in.bin_real  = 16'sh8000;
            rsp_in.saturated = 1'b1;
         end else begin
            rsp_in.bin_real  = -$signed(rnd[RESULT_W-1:0]);
            rsp_in.saturated = 1'b0;
         end
      end else begin
         if (rnd > RND_W'(32767)) begin
            rsp_in.bin_real  = 16'sh7FFF;
            rsp_in.saturated = 1'b1;
         end else begin
            rsp_in.bin_real  = $signed(rnd[RESULT_W-1:0]);
            rsp_in.saturated = 1'b0;
         end
      end
   end

   assign prod_in = $signed({1'b0, ram_rdata}) * cos_ff;

   // Control: sequencer, address counter, result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == ADDR_W'(POINTS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               addr_ff <= '0;
               if (accept_bin) state_ff <= ST_RUN;
            end
            ST_RUN: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == ADDR_W'(POINTS - 1)) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!rd_v_ff && !prod_v_ff) state_ff <= ST_ABS;
            end
            ST_ABS: begin
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Pipeline valids: read data, then product.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= (state_ff == ST_RUN);
         prod_v_ff <= rd_v_ff;
      end
   end

   // MAC datapath. Phase tracks (m*k) mod POINTS by adding k each read.
   always_ff @(posedge clock) begin
      if (accept_bin) begin
         k_ff     <= ADDR_W'(req_data.index);
         bin_ff   <= req_data.index;
         phase_ff <= '0;
         acc_ff   <= '0;
      end else begin
         if (state_ff == ST_RUN) phase_ff <= phase_ff + k_ff;
         if (prod_v_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      cos_ff  <= $signed(COS_TABLE[phase_ff]);
      prod_ff <= prod_in;
      if (state_ff == ST_ABS) begin
         mag_ff <= mag_in;
         neg_ff <= acc_ff[ACC_W-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // A bin request beat always puts the engine into its busy run.
   a_bin_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_BIN) |=> (busy && state_ff == ST_RUN))
      else $error("bin request did not start the MAC run");

   // Nothing left in the MAC pipeline once the engine reports idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_v_ff && !prod_v_ff))
      else $error("MAC pipeline active while idle");

   // A result only follows the rounding step.
   a_rsp_after_round: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_ROUND))
      else $error("result strobe without rounding step");

endmodule

// ===== design/dftrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Parameters set width and depth. No dependencies.
module dftrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/dft_real_bin_engine_tb.sv =====
// Self-checking testbench for dft_real_bin_engine: keeps its own sample memory and cosine
// table, predicts every bin beat and checks the result strobe field by field.
// Depends on dftrb_pkg (beat structs, command codes, POINTS) and the RTL.
module dft_real_bin_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dftrb_pkg::*;

   // Pi in Q30, as used to build the Q2.14 cosine table.
   localparam longint unsigned PI_Q30_LOCAL = 64'd3373259426;
   localparam int COS_TERMS = 12;
   // Longest quiet stretch of a correct run: the clearing pass after reset, or
   // one bin plus the longest sender gap. The limit allows about ten times that.
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_PRINTS = 50;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   dft_real_bin_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: mirror of the sample RAM and the Q2.14 cosine table.
   // ---------------------------------------------------------------------
   logic [15:0]        sample_mem [POINTS];
   logic signed [15:0] cos_lut    [POINTS];
   rsp_type            bins_pending [$];   // predicted bin beats, oldest first
   int                 mismatches  = 0;
   int                 beats_sent  = 0;
   int                 idle_pct    = 0;    // sender idle odds per cycle, percent
   int                 idle_cycles = 0;

   // Cosine table, built the same way the hardware defines it: fold the angle
   // into the first quadrant, Taylor series in Q30, round to Q14, re-apply sign.
   initial begin : build_cosines
      longint unsigned p, a, theta, t2, term, qmag;
      longint          s;
      logic            neg;
      logic signed [15:0] qv;
      for (int i = 0; i < POINTS; i++) begin
         p   = i;
         neg = 1'b0;
         if (2 * p > POINTS) p = POINTS - p;
         a = 2 * p;
         if (2 * a > POINTS) begin
            a   = POINTS - a;
            neg = 1'b1;
         end
         theta = (PI_Q30_LOCAL * a) / POINTS;
         t2    = (theta * theta) >> 30;
         term  = 64'd1 << 30;
         s     = longint'(term);
         for (int n = 1; n <= COS_TERMS; n++) begin
            term = ((term * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) s = s - longint'(term);
            else            s = s + longint'(term);
         end
         if (s < 0) s = 0;
         qmag       = (longint'(s) + 32768) >> 16;
         qv         = qmag[15:0];
         cos_lut[i] = neg ? -qv : qv;
      end
      foreach (sample_mem[i]) sample_mem[i] = '0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < MAX_PRINTS)
         $display("[%0t] ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: check the result strobe first, then predict whatever beat
   // the block takes at this same edge. One process, so ordering is fixed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      longint  acc, mag, r, val;
      int      k;
      if (!reset) begin
         if (rsp_valid) begin
            if (bins_pending.size() == 0) begin
               report_mismatch("result with no bin pending", rsp_data.bin_number, -1);
            end else begin
               want = bins_pending.pop_front();
               if (rsp_data.bin_real !== want.bin_real)
                  report_mismatch("bin_real", longint'(rsp_data.bin_real),
                                  longint'(want.bin_real));
               if (rsp_data.bin_number !== want.bin_number)
                  report_mismatch("bin_number", rsp_data.bin_number, want.bin_number);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_data.saturated, want.saturated);
            end
         end
         if (start && !busy) begin
            if (req_data.cmd == CMD_WRITE) begin
               // 7-bit index never reaches POINTS, so every write lands.
               sample_mem[req_data.index] = req_data.sample;
            end else begin
               k   = int'(req_data.index) % POINTS;
               acc = 0;
               for (int m = 0; m < POINTS; m++)
                  acc += longint'(sample_mem[m]) * longint'(cos_lut[(m * k) % POINTS]);
               // Q.14 sum -> integer, half away from zero, then clamp to int16.
               mag            = (acc < 0) ? -acc : acc;
               r              = (mag + 8192) >>> 14;
               want.saturated = 1'b0;
               if (acc < 0) begin
                  if (r > 32768) begin
                     val            = -32768;
                     want.saturated = 1'b1;
                  end else begin
                     val = -r;
                  end
               end else if (r > 32767) begin
                  val            = 32767;
                  want.saturated = 1'b1;
               end else begin
                  val = r;
               end
               want.bin_real   = val[15:0];
               want.bin_number = req_data.index;
               bins_pending.push_back(want);
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Present one beat and hold it until the block takes it. start is left high
   // when no gap follows, so back-to-back beats never drop start for a step.
   task automatic send_beat(input logic cmd_bit, input logic [INDEX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] value);
      req_type beat;
      int      gap;
      beat.cmd    = cmd_bit;
      beat.index  = idx;
      beat.sample = value;
      req_data <= beat;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      beats_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_sample(input int idx, input logic [SAMPLE_W-1:0] value);
      send_beat(CMD_WRITE, idx[INDEX_W-1:0], value);
   endtask

   // Sample field is don't-care on a request; keep it toggling.
   task automatic request_bin(input int k);
      send_beat(CMD_BIN, k[INDEX_W-1:0], 16'($urandom));
   endtask

   // Sender holds off until every predicted bin beat has come back. It first
   // steps past the current edge, so a bin taken there is already in the queue.
   task automatic hold_off_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (bins_pending.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Store is cleared by reset, so every bin reads back zero.
   task automatic test_cleared_store();
      request_bin(0);
      request_bin(64);
      request_bin(127);
   endtask

   // Clamp at both int16 limits, plus the exact limits that must not clamp.
   task automatic test_saturation();
      write_sample(0, 16'hFFFF);
      request_bin(0);              // +65535 -> clamps high
      write_sample(1, 16'hFFFF);
      request_bin(64);             // alternating signs cancel to zero
      write_sample(0, 16'h0000);
      request_bin(64);             // -65535 -> clamps low
      write_sample(1, 16'h8000);
      request_bin(64);             // exactly -32768, no clamp
      write_sample(1, 16'h0000);
      write_sample(0, 16'h7FFF);
      request_bin(0);              // exactly +32767, no clamp
      write_sample(0, 16'h8000);
      request_bin(0);              // +32768 -> clamps high
   endtask

   // Half-way sums round away from zero in both directions; odd bit patterns.
   task automatic test_rounding();
      write_sample(0, 16'h0000);
      write_sample(1, 16'h2000);
      request_bin(16);             // 8192 * cos(pi/4) lands on .5
      request_bin(48);             // same magnitude, negative
      write_sample(1, 16'h0000);
      write_sample(127, 16'h5555);
      write_sample(126, 16'hAAAA);
      request_bin(1);
      send_beat(CMD_BIN, 7'h7F, 16'hFFFF);
      write_sample(127, 16'h0000);
      write_sample(126, 16'h0000);
   endtask

   // Bursts of writes followed by a few bin requests. Sample profiles keep most
   // bins in range; runs of zeros pull the store back down from saturation.
   task automatic test_random_traffic(input int items);
      int first, profile, burst, base, idx, k;
      logic [SAMPLE_W-1:0] value;
      first = beats_sent;
      while (beats_sent - first < items) begin
         profile = $urandom_range(9);
         burst   = $urandom_range(1, 24);
         base    = $urandom_range(POINTS - 1);
         if ($urandom_range(7) == 0) begin
            // noise: commands, indexes and payloads all random
            repeat (burst % 6 + 1)
               send_beat(1'($urandom), 7'($urandom), 16'($urandom));
         end else begin
            for (int i = 0; i < burst; i++) begin
               idx = (profile >= 8) ? (base + i) % POINTS : $urandom_range(POINTS - 1);
               case (profile)
                  0, 1, 2, 3: value = 16'($urandom_range(255));
                  4, 5:       value = 16'($urandom_range(4095));
                  6:          value = 16'($urandom);
                  7:          value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                  default:    value = '0;
               endcase
               write_sample(idx, value);
            end
            repeat ($urandom_range(1, 3)) begin
               k = ($urandom_range(3) == 0) ? 32 * $urandom_range(3)
                                            : $urandom_range(POINTS - 1);
               request_bin(k);
            end
         end
         if ($urandom_range(9) == 0) hold_off_until_drained();
      end
      hold_off_until_drained();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, sender idle odds at 37 percent.
      idle_pct = 37;
      test_cleared_store();
      test_saturation();
      test_rounding();
      hold_off_until_drained();

      // Random part in three idling regimes.
      test_random_traffic(210);
      idle_pct = 58;
      test_random_traffic(210);
      idle_pct = 0;
      test_random_traffic(210);

      hold_off_until_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/dftrb_pkg.sv
design/dftrb_ram.sv
design/dft_real_bin_engine.sv
bench/dft_real_bin_engine_tb.sv
